@@ sv/wmks_pkg.sv @@
// Package: shared types and constants for the weighted merged k-th select block.
`timescale 1ns / 1ps
package wmks_pkg;
  localparam int unsigned FirstDepthDef  = 1024;
  localparam int unsigned SecondDepthDef = 1024;
  localparam int unsigned ValW   = 31;
  localparam int unsigned CntW   = 31;
  localparam int unsigned LenW   = 11;
  localparam int unsigned ScaleW = 30;
  localparam logic signed [ValW-1:0] SearchLow  = -31'sd1000000000;
  localparam logic signed [ValW-1:0] SearchHigh = 31'sd1000000000;

  typedef enum logic [1:0] {
    REQ_LOAD_FIRST  = 2'd0,
    REQ_LOAD_SECOND = 2'd1,
    REQ_QUERY       = 2'd2,
    REQ_NONE        = 2'd3
  } req_type_e;

  localparam logic CfgFirstLen  = 1'b0;
  localparam logic CfgSecondLen = 1'b1;

  // Division unit status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

@@ sv/wmks_floor_div.sv @@
// Floor division of a signed numerator by a positive divisor, one bit per cycle.
`timescale 1ns / 1ps
module wmks_floor_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [32:0]                    num_i,
  input  logic [wmks_pkg::ScaleW-1:0]           den_i,
  output logic signed [33:0]                    quo_o,
  output wmks_pkg::div_stat_t                   stat_o
);
  import wmks_pkg::*;

  localparam int unsigned NW = 33;

  logic [NW-1:0]     mag_q, mag_d;
  logic [ScaleW:0]   rem_q, rem_d;
  logic [ScaleW-1:0] den_q, den_d;
  logic              neg_q, neg_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [ScaleW:0]   shifted;
  logic              ge;
  logic              rem_nz;
  logic signed [33:0] q_ext;

  always_comb begin
    shifted = {rem_q[ScaleW-1:0], mag_q[NW-1]};
    ge      = shifted >= {1'b0, den_q};
    rem_nz  = (rem_q != '0);
    q_ext   = $signed({1'b0, mag_q});
    mag_d = mag_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      neg_d  = num_i[32];
      mag_d  = num_i[32] ? NW'(-num_i) : NW'(num_i);
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? shifted - {1'b0, den_q} : shifted;
      mag_d = {mag_q[NW-2:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Negative numerator: floor = -(q) - 1 when remainder is nonzero.
  assign quo_o = neg_q ? (rem_nz ? -q_ext - 34'sd1 : -q_ext) : q_ext;
  assign stat_o = '{busy: busy_q, done: done_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
endmodule

@@ sv/weighted_merged_kth_select_top.sv @@
// Top level: list memories, search sequencer and stream ports.
`timescale 1ns / 1ps
// Weighted k-th select over two sorted lists with multiplicities.
// Input stream s_axis: one transaction per load or query (tuser carries req_type).
// Loads write value at entry_index and running prefix count at entry_index+1 and give no result.
// A load reads the prefix at entry_index, then writes back.
// Queries binary-search candidates in [-1e9, 1e9], up to 31 candidates. Each
// candidate takes a midpoint state, two upper-bound searches over the value
// memories (up to log2(depth)+1 steps each), a 33-step floor divider that
// holds the sequencer until it is done, and a read and sum of the prefix
// counts. A zero scale skips the divider and the second search.
// Config writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) set the list lengths; the
// lengths in use saturate to the memory depth.
// Result stream m_axis: one transaction per query. The result sits in an
// output register; a stalled receiver holds it, and a following query waits in
// its last state until the register frees up. Reset empties the pipeline and
// sets both lengths to zero; the memories are undefined, but prefix entry zero reads as zero.
module weighted_merged_kth_select_top #(
  parameter int unsigned FIRST_DEPTH  = wmks_pkg::FirstDepthDef,
  parameter int unsigned SECOND_DEPTH = wmks_pkg::SecondDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [10:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [9:0] entry_index, [40:10] entry_value, [60:41] entry_count,
  // [90:61] scale_a, [121:91] offset_b, [152:122] rank_k, [159:153] zero
  input  logic [159:0] s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [30:0] kth_value, [31] zero
  output logic [31:0]  m_axis_tdata_o,
  // [0] found
  output logic         m_axis_tuser_o
);
  import wmks_pkg::*;

  localparam int unsigned AW1 = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int unsigned AW2 = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int unsigned PW1 = $clog2(FIRST_DEPTH + 1);
  localparam int unsigned PW2 = $clog2(SECOND_DEPTH + 1);
  localparam int unsigned PW  = (PW1 > PW2) ? PW1 : PW2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_RD, ST_LD_WR, ST_MID, ST_S1_ADR, ST_S1_CMP, ST_DIV,
    ST_S2_ADR, ST_S2_CMP, ST_P_RD, ST_P_SUM, ST_OUT
  } state_e;

  // Memories.
  logic [ValW-1:0] v1_mem [FIRST_DEPTH];
  logic [ValW-1:0] v2_mem [SECOND_DEPTH];
  logic [CntW-1:0] p1_mem [FIRST_DEPTH+1];
  logic [CntW-1:0] p2_mem [SECOND_DEPTH+1];
  logic [ValW-1:0] v1_rd_q, v2_rd_q;
  logic [CntW-1:0] p1_rd_q, p2_rd_q;

  state_e state_q;
  logic [LenW-1:0] len1_q, len2_q;
  logic [1:0]  typ_q;
  logic [9:0]  idx_q;
  logic signed [ValW-1:0] val_q;
  logic [19:0] cnt_q;
  logic [ScaleW-1:0] a_q;
  logic signed [ValW-1:0] b_q;
  logic [30:0] k_q;
  logic signed [ValW:0] lo_q, hi_q;
  logic signed [ValW-1:0] mid_q, ans_q;
  logic found_q;
  logic signed [33:0] key_q;
  logic [PW:0] slo_q, shi_q;
  logic [PW-1:0] pos1_q;
  logic div_start_q;
  logic out_v_q;
  logic [ValW-1:0] out_d_q;
  logic out_f_q;
  logic p1_z_q, p2_z_q;

  logic [PW:0] n1, n2, smid;
  logic signed [33:0] div_q;
  div_stat_t div_st;
  logic [PW:0] p1_addr_w, p2_addr_w;
  logic ld_first;
  logic signed [32:0] num;
  logic [CntW:0] total;

  assign n1 = (32'(len1_q) > FIRST_DEPTH) ? (PW+1)'(FIRST_DEPTH) : (PW+1)'(len1_q);
  assign n2 = (32'(len2_q) > SECOND_DEPTH) ? (PW+1)'(SECOND_DEPTH) : (PW+1)'(len2_q);
  assign smid = slo_q + ((shi_q - slo_q) >> 1);
  assign num  = 33'(mid_q) - 33'(b_q);
  assign ld_first = (typ_q == REQ_LOAD_FIRST);
  assign total = (CntW+1)'(p1_z_q ? '0 : p1_rd_q) + (CntW+1)'(p2_z_q ? '0 : p2_rd_q);

  wmks_floor_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start_q),
    .num_i   (num),
    .den_i   (a_q),
    .quo_o   (div_q),
    .stat_o  (div_st)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {1'b0, out_d_q};
  assign m_axis_tuser_o  = out_f_q;

  // Value memory reads: address is the search midpoint.
  always_ff @(posedge clk_i) begin
    v1_rd_q <= v1_mem[AW1'(smid)];
    v2_rd_q <= v2_mem[AW2'(smid)];
    if (state_q == ST_LD_WR && ld_first && 32'(idx_q) < FIRST_DEPTH)
      v1_mem[AW1'(idx_q)] <= val_q;
    if (state_q == ST_LD_WR && !ld_first && 32'(idx_q) < SECOND_DEPTH)
      v2_mem[AW2'(idx_q)] <= val_q;
  end

  // Prefix memories: read address depends on phase; entry zero reads as zero.
  always_comb begin
    p1_addr_w = (PW+1)'(idx_q);
    p2_addr_w = (PW+1)'(idx_q);
    if (state_q == ST_P_RD) begin
      p1_addr_w = (PW+1)'(pos1_q);
      p2_addr_w = (a_q == '0) ? n2 : slo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_rd_q <= p1_mem[PW1'(p1_addr_w)];
    p2_rd_q <= p2_mem[PW2'(p2_addr_w)];
    if (state_q == ST_LD_WR && ld_first && 32'(idx_q) < FIRST_DEPTH)
      p1_mem[PW1'(idx_q) + PW1'(1)] <= CntW'((p1_z_q ? '0 : p1_rd_q) + CntW'(cnt_q));
    if (state_q == ST_LD_WR && !ld_first && 32'(idx_q) < SECOND_DEPTH)
      p2_mem[PW2'(idx_q) + PW2'(1)] <= CntW'((p2_z_q ? '0 : p2_rd_q) + CntW'(cnt_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len1_q <= '0; len2_q <= '0;
      out_v_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_addr_i == CfgFirstLen) len1_q <= cfg_wdata_i;
        else len2_q <= cfg_wdata_i;
      end
      if (out_v_q && m_axis_tready_i) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (s_axis_tvalid_i) begin
          typ_q <= s_axis_tuser_i;
          idx_q <= s_axis_tdata_i[9:0];
          val_q <= s_axis_tdata_i[40:10];
          cnt_q <= s_axis_tdata_i[60:41];
          a_q   <= s_axis_tdata_i[90:61];
          b_q   <= s_axis_tdata_i[121:91];
          k_q   <= s_axis_tdata_i[152:122];
          lo_q  <= 32'(SearchLow);
          hi_q  <= 32'(SearchHigh);
          ans_q <= -31'sd1;
          found_q <= 1'b0;
          case (req_type_e'(s_axis_tuser_i))
            REQ_LOAD_FIRST, REQ_LOAD_SECOND: state_q <= ST_LD_RD;
            REQ_QUERY: state_q <= ST_MID;
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_LD_RD: begin
          p1_z_q <= (idx_q == '0);
          p2_z_q <= (idx_q == '0);
          state_q <= ST_LD_WR;
        end
        ST_LD_WR: state_q <= ST_IDLE;
        ST_MID: begin
          if (lo_q > hi_q) begin
            state_q <= ST_OUT;
          end else begin
            // floor((lo+hi)/2) via arithmetic shift
            mid_q <= ValW'((33'(lo_q) + 33'(hi_q)) >>> 1);
            slo_q <= '0;
            shi_q <= n1;
            state_q <= ST_S1_ADR;
          end
        end
        ST_S1_ADR: begin
          if (slo_q < shi_q) state_q <= ST_S1_CMP;
          else begin
            pos1_q <= PW'(slo_q);
            // a zero scale needs no quotient; keep the divider idle
            div_start_q <= (a_q != '0);
            state_q <= ST_DIV;
          end
        end
        ST_S1_CMP: begin
          if ($signed(v1_rd_q) <= mid_q) slo_q <= smid + 1'b1;
          else shi_q <= smid;
          state_q <= ST_S1_ADR;
        end
        ST_DIV: if (a_q == '0 || div_st.done) begin
          key_q <= div_q;
          slo_q <= '0;
          shi_q <= (a_q == '0) ? '0 : n2;
          state_q <= ST_S2_ADR;
        end
        ST_S2_ADR: state_q <= (slo_q < shi_q) ? ST_S2_CMP : ST_P_RD;
        ST_S2_CMP: begin
          if (34'($signed(v2_rd_q)) <= key_q) slo_q <= smid + 1'b1;
          else shi_q <= smid;
          state_q <= ST_S2_ADR;
        end
        ST_P_RD: begin
          p1_z_q <= (pos1_q == '0);
          p2_z_q <= (a_q == '0) ? (b_q > mid_q || n2 == '0) : (slo_q == '0);
          state_q <= ST_P_SUM;
        end
        // Compare the summed counts against the rank and narrow the range.
        ST_P_SUM: begin
          if (total >= (CntW+1)'(k_q)) begin
            ans_q <= mid_q;
            found_q <= 1'b1;
            hi_q <= 32'(mid_q) - 32'sd1;
          end else begin
            lo_q <= 32'(mid_q) + 32'sd1;
          end
          state_q <= ST_MID;
        end
        ST_OUT: if (!out_v_q) begin
          out_v_q <= 1'b1;
          out_d_q <= ans_q;
          out_f_q <= found_q;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready_i |=> out_v_q) else $error("result dropped");
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_S1_CMP |-> shi_q <= n1) else $error("search past length");
endmodule
